// ----- src/ccrc_pkg.sv -----
package ccrc_pkg;

	// width of the result word on the output stream
	localparam int CRC_BITS = 64;

	// config register index
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_WIDTH      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLYNOMIAL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_NONDIRECT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REFLECT_IN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REFLECT_OUT    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_XOR_OUT        = 3'd6;

	// width field of the config register file
	localparam int WIDTH_REG_W = 7;

	// bit order flags handed to the datapath
	typedef struct packed {
		logic reflect_in;
		logic reflect_out;
	} flags_t;

endpackage

// ----- src/ccrc_cfg.sv -----
module ccrc_cfg import ccrc_pkg::*; #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CRC_BITS-1:0]        cfg_data,
	output logic [MAX_WIDTH-1:0]       poly_al,
	output logic [MAX_WIDTH-1:0]       xor_m,
	output logic [$clog2(MAX_WIDTH)-1:0] sh,
	output logic [MAX_WIDTH-1:0]       start_al,
	output flags_t                     flags,
	output logic                       realign,
	output logic                       idle
);

	localparam int W  = MAX_WIDTH;
	localparam int SW = $clog2(MAX_WIDTH);
	localparam logic [WIDTH_REG_W-1:0] W_MAX = WIDTH_REG_W'(MAX_WIDTH);

	logic [WIDTH_REG_W-1:0] width_q;
	logic [W-1:0]           poly_q;
	logic [W-1:0]           init_q;
	logic                   nondirect_q;
	logic                   rin_q;
	logic                   rout_q;
	logic [W-1:0]           xout_q;

	logic                   load_q;
	logic                   busy_q;
	logic [WIDTH_REG_W-1:0] cnt_q;
	logic [W-1:0]           start_q;

	logic [WIDTH_REG_W-1:0] w_eff;
	logic [W-1:0]           mask;
	logic [W-1:0]           start_nxt;
	logic                   cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	// effective width, clamped to 1..MAX_WIDTH
	always_comb begin
		priority if (width_q == '0) begin
			w_eff = WIDTH_REG_W'(1);
		end else if (width_q > W_MAX) begin
			w_eff = W_MAX;
		end else begin
			w_eff = width_q;
		end
	end

	// alignment: the remainder is kept msb aligned in the datapath
	assign sh      = SW'(W_MAX - w_eff);
	assign mask    = {W{1'b1}} >> sh;
	assign poly_al = poly_q << sh;
	assign xor_m   = xout_q & mask;

	assign flags.reflect_in  = rin_q;
	assign flags.reflect_out = rout_q;
	assign start_al = start_q;
	assign realign  = load_q;
	assign idle     = ~load_q & ~busy_q;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= WIDTH_REG_W'(32);
			poly_q      <= W'(64'h0000_0000_04C1_1DB7);
			init_q      <= W'(64'h0000_0000_FFFF_FFFF);
			nondirect_q <= 1'b0;
			rin_q       <= 1'b1;
			rout_q      <= 1'b1;
			xout_q      <= W'(64'h0000_0000_FFFF_FFFF);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_CRC_WIDTH:      width_q     <= cfg_data[WIDTH_REG_W-1:0];
				REG_POLYNOMIAL:     poly_q      <= cfg_data[W-1:0];
				REG_INIT_VALUE:     init_q      <= cfg_data[W-1:0];
				REG_INIT_NONDIRECT: nondirect_q <= cfg_data[0];
				REG_REFLECT_IN:     rin_q       <= cfg_data[0];
				REG_REFLECT_OUT:    rout_q      <= cfg_data[0];
				REG_XOR_OUT:        xout_q      <= cfg_data[W-1:0];
				default: ;
			endcase
		end
	end

	// start value: up to eight zero bits shifted through per cycle
	always_comb begin
		logic [W-1:0] r;
		r = start_q;
		for (int i = 0; i < 8; i++) begin
			if (WIDTH_REG_W'(i) < cnt_q) begin
				r = r[W-1] ? ((r << 1) ^ poly_al) : (r << 1);
			end
		end
		start_nxt = r;
	end

	// start value sequencer, restarted by every config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q  <= 1'b1;
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			start_q <= '0;
		end else if (cfg_wr) begin
			load_q <= 1'b1;
			busy_q <= 1'b0;
		end else if (load_q) begin
			load_q  <= 1'b0;
			start_q <= init_q << sh;
			cnt_q   <= w_eff;
			busy_q  <= nondirect_q;
		end else if (busy_q) begin
			start_q <= start_nxt;
			if (cnt_q > WIDTH_REG_W'(8)) begin
				cnt_q <= cnt_q - WIDTH_REG_W'(8);
			end else begin
				cnt_q  <= '0;
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/ccrc_step.sv -----
module ccrc_step import ccrc_pkg::*; #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [7:0]                   data_byte,
	input  logic                         last_byte,
	input  flags_t                       flags,
	input  logic [MAX_WIDTH-1:0]         poly_al,
	input  logic [MAX_WIDTH-1:0]         start_al,
	input  logic [$clog2(MAX_WIDTH)-1:0] sh,
	input  logic                         realign,
	input  logic                         fin_take,
	output logic                         fin_valid,
	output logic [MAX_WIDTH-1:0]         fin_rem
);

	localparam int W  = MAX_WIDTH;
	localparam int SW = $clog2(MAX_WIDTH);

	logic          in_msg_q;
	logic [W-1:0]  rem_q;
	logic [SW-1:0] sh_q;
	logic          fin_valid_s1;
	logic [W-1:0]  fin_rem_s1;
	logic [W-1:0]  rem_nxt;

	// one byte through the msb aligned register, eight bit steps
	always_comb begin
		logic [W-1:0] r;
		logic         b;
		r = in_msg_q ? rem_q : start_al;
		for (int i = 0; i < 8; i++) begin
			b = flags.reflect_in ? data_byte[i] : data_byte[7-i];
			r = (r[W-1] ^ b) ? ((r << 1) ^ poly_al) : (r << 1);
		end
		rem_nxt = r;
	end

	// running remainder; width changes move it to the new alignment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
			rem_q    <= '0;
			sh_q     <= '0;
		end else if (realign) begin
			rem_q <= (rem_q >> sh_q) << sh;
			sh_q  <= sh;
		end else if (accept) begin
			rem_q    <= rem_nxt;
			in_msg_q <= ~last_byte;
		end
	end

	// finished remainder waiting for the output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s1 <= 1'b0;
		end else if (accept && last_byte) begin
			fin_valid_s1 <= 1'b1;
		end else if (fin_take) begin
			fin_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			fin_rem_s1 <= rem_nxt;
		end
	end

	assign fin_valid = fin_valid_s1;
	assign fin_rem   = fin_rem_s1;

endmodule

// ----- src/ccrc_fin.sv -----
module ccrc_fin import ccrc_pkg::*; #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fin_valid,
	input  logic [MAX_WIDTH-1:0]         fin_rem,
	output logic                         fin_take,
	input  flags_t                       flags,
	input  logic [$clog2(MAX_WIDTH)-1:0] sh,
	input  logic [MAX_WIDTH-1:0]         xor_m,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [MAX_WIDTH-1:0]         out_crc,
	output logic                         out_zero
);

	localparam int W = MAX_WIDTH;

	logic         out_valid_q;
	logic [W-1:0] out_crc_q;
	logic         out_zero_q;
	logic [W-1:0] rev;
	logic [W-1:0] crc;

	// bit reversal of the aligned remainder equals reflection over the width
	always_comb begin
		for (int i = 0; i < W; i++) begin
			rev[i] = fin_rem[W-1-i];
		end
	end

	assign crc      = (flags.reflect_out ? rev : (fin_rem >> sh)) ^ xor_m;
	assign fin_take = fin_valid & (~out_valid_q | out_ready);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_take) begin
			out_crc_q  <= crc;
			out_zero_q <= (crc == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_crc   = out_crc_q;
	assign out_zero  = out_zero_q;

endmodule

// ----- src/configurable_crc_engine_top.sv -----
// channel   | signals                          | beat
// ----------+----------------------------------+------------------------------------------
// s_axis    | tvalid tready tdata[7:0] tlast   | one message byte, tlast on the final byte
// m_axis    | tvalid tready tdata[63:0] tuser  | final crc, tuser set when the crc is zero
// cfg       | valid ready index[2:0] data[63:0]| one register write
//
// one byte per clock while the input is not stalled; the crc of a message passes from the
// finished remainder register to the result register and is held there until m_axis takes it.
// the input stalls while a finished crc waits behind a full result register.
// after reset and after each config write the input stalls while the start value is loaded,
// and also while the start value unit converts an init value given in non-direct form.
// arst_n clears control state; the config registers return to the crc-32 set.
module configurable_crc_engine_top import ccrc_pkg::*; #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // [7:0] data_byte
	input  logic                 s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [CRC_BITS-1:0]  m_axis_tdata,  // [63:0] crc_value
	output logic                 m_axis_tuser,  // [0] crc_is_zero
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CRC_BITS-1:0]  cfg_data
);

	localparam int W  = MAX_WIDTH;
	localparam int SW = $clog2(MAX_WIDTH);

	logic [W-1:0]  poly_al;
	logic [W-1:0]  xor_m;
	logic [SW-1:0] sh;
	logic [W-1:0]  start_al;
	flags_t        flags;
	logic          realign;
	logic          idle;
	logic          accept;
	logic          fin_valid;
	logic [W-1:0]  fin_rem;
	logic          fin_take;
	logic [W-1:0]  out_crc;

	// config registers and start value
	ccrc_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.poly_al   (poly_al),
		.xor_m     (xor_m),
		.sh        (sh),
		.start_al  (start_al),
		.flags     (flags),
		.realign   (realign),
		.idle      (idle)
	);

	// input handshake
	assign s_axis_tready = idle & (~fin_valid | fin_take);
	assign accept        = s_axis_tvalid & s_axis_tready;

	// byte update of the remainder
	ccrc_step #(.MAX_WIDTH(MAX_WIDTH)) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (s_axis_tdata),
		.last_byte (s_axis_tlast),
		.flags     (flags),
		.poly_al   (poly_al),
		.start_al  (start_al),
		.sh        (sh),
		.realign   (realign),
		.fin_take  (fin_take),
		.fin_valid (fin_valid),
		.fin_rem   (fin_rem)
	);

	// reflect, xor and output register
	ccrc_fin #(.MAX_WIDTH(MAX_WIDTH)) u_fin (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin_valid (fin_valid),
		.fin_rem   (fin_rem),
		.fin_take  (fin_take),
		.flags     (flags),
		.sh        (sh),
		.xor_m     (xor_m),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_crc   (out_crc),
		.out_zero  (m_axis_tuser)
	);

	assign m_axis_tdata = CRC_BITS'(out_crc);

endmodule

// ----- dv/tb.sv -----
module tb;
	import ccrc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W = 64;
	localparam int DRAIN_CYCLES = 8;
	localparam int STUCK_LIMIT = 5000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic [63:0] crc_value;
		logic        crc_is_zero;
	} crc_result_t;

	// running crc of the byte stream and the crcs still owed by the block
	class crc_checker;
		logic [6:0]  width_reg;
		logic [63:0] poly_reg;
		logic [63:0] init_reg;
		logic        nondirect_reg;
		logic        refin_reg;
		logic        refout_reg;
		logic [63:0] xor_reg;
		logic [63:0] remainder;
		bit          in_msg;
		crc_result_t crc_due_q[$];
		int          n_fail;
		int          n_bytes;
		int          n_checked;

		function new();
			width_reg     = 7'd32;
			poly_reg      = 64'h04C1_1DB7;
			init_reg      = 64'hFFFF_FFFF;
			nondirect_reg = 1'b0;
			refin_reg     = 1'b1;
			refout_reg    = 1'b1;
			xor_reg       = 64'hFFFF_FFFF;
			remainder     = '0;
			in_msg        = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
			case (idx)
				REG_CRC_WIDTH:      width_reg = d[6:0];
				REG_POLYNOMIAL:     poly_reg = d;
				REG_INIT_VALUE:     init_reg = d;
				REG_INIT_NONDIRECT: nondirect_reg = d[0];
				REG_REFLECT_IN:     refin_reg = d[0];
				REG_REFLECT_OUT:    refout_reg = d[0];
				REG_XOR_OUT:        xor_reg = d;
				default: ;
			endcase
		endfunction

		// width in use, clamped to 1..MAX_W
		function int active_width();
			int w;
			w = int'(width_reg);
			if (w < 1) w = 1;
			if (w > MAX_W) w = MAX_W;
			return w;
		endfunction

		function logic [63:0] width_mask(int w);
			return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
		endfunction

		// one bit through the direct-form shift register
		function logic [63:0] shift_bit(logic [63:0] r, logic b, int w);
			logic [63:0] m;
			logic        top;
			m = width_mask(w);
			top = r[w-1] ^ b;
			r = (r << 1) & m;
			if (top) r = r ^ (poly_reg & m);
			return r;
		endfunction

		function logic [63:0] mirror(logic [63:0] v, int w);
			logic [63:0] r;
			r = '0;
			for (int i = 0; i < w; i++) begin
				r = (r << 1) | (v & 64'd1);
				v = v >> 1;
			end
			return r;
		endfunction

		function void take_byte(logic [7:0] d, logic last);
			int          w;
			logic [63:0] m;
			logic [63:0] crc;
			crc_result_t res;
			w = active_width();
			m = width_mask(w);
			n_bytes++;
			// start value at message start, non-direct init pushed through w zeros
			if (!in_msg) begin
				remainder = init_reg & m;
				if (nondirect_reg)
					for (int i = 0; i < w; i++) remainder = shift_bit(remainder, 1'b0, w);
			end
			remainder = remainder & m;
			for (int i = 0; i < 8; i++)
				remainder = shift_bit(remainder, refin_reg ? d[i] : d[7-i], w);
			if (!last) begin
				in_msg = 1;
				return;
			end
			in_msg = 0;
			// reflection comes before the final xor
			crc = refout_reg ? mirror(remainder, w) : remainder;
			crc = (crc ^ xor_reg) & m;
			res.crc_value = crc;
			res.crc_is_zero = (crc == '0);
			crc_due_q.push_back(res);
		endfunction

		function void check_result(logic [63:0] crc, logic is_zero);
			crc_result_t exp;
			if (crc_due_q.size() == 0) begin
				$error("unexpected crc beat: crc_value %h crc_is_zero %b", crc, is_zero);
				n_fail++;
				return;
			end
			exp = crc_due_q.pop_front();
			n_checked++;
			if (crc !== exp.crc_value) begin
				$error("crc_value mismatch: expected %h, actual %h", exp.crc_value, crc);
				n_fail++;
			end
			if (is_zero !== exp.crc_is_zero) begin
				$error("crc_is_zero mismatch: expected %b, actual %b", exp.crc_is_zero,
					is_zero);
				n_fail++;
			end
		endfunction

		function int pending();
			return crc_due_q.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata;
	logic                 s_axis_tlast;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [CRC_BITS-1:0]  m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CRC_BITS-1:0]  cfg_data;

	crc_checker sb = new();
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int hold_req = 0;
	int n_settings = 0;
	int n_msgs = 0;
	int stuck_cycles = 0;

	configurable_crc_engine_top #(.MAX_WIDTH(MAX_W)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", STUCK_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	// result side: random stalls, long hold-off on request, check each beat
	initial begin
		int hold_left;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
			end
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata, m_axis_tuser);
		end
	end

	// one message byte, valid left high for the next beat
	task automatic send_byte(input logic [7:0] d, input logic last);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tlast <= last;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		sb.take_byte(d, last);
		if (last) n_msgs++;
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		sb.write_reg(idx, d);
		@(negedge clk);
	endtask

	// all seven registers, then release the channel
	task automatic program_crc(input logic [6:0] w, input logic [63:0] p, input logic [63:0] iv,
		input logic nd, input logic ri, input logic ro, input logic [63:0] xv);
		cfg_write(REG_CRC_WIDTH, {$urandom(), 25'd0, w});
		cfg_write(REG_POLYNOMIAL, p);
		cfg_write(REG_INIT_VALUE, iv);
		cfg_write(REG_INIT_NONDIRECT, {$urandom(), 31'd0, nd});
		cfg_write(REG_REFLECT_IN, {$urandom(), 31'd0, ri});
		cfg_write(REG_REFLECT_OUT, {$urandom(), 31'd0, ro});
		cfg_write(REG_XOR_OUT, xv);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// drop valid, let owed crcs drain and the pipeline settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_setting();
		int sel;
		logic [6:0] w;
		sel = $urandom_range(0, 9);
		case (sel)
			0: program_crc(7'd32, 64'h04C1_1DB7, 64'hFFFF_FFFF, 1'b0, 1'b1, 1'b1,
				64'hFFFF_FFFF);
			1: program_crc(7'd16, 64'h1021, 64'hFFFF, 1'b0, 1'b0, 1'b0, 64'h0);
			2: program_crc(7'd64, 64'h42F0_E1EB_A9EA_3693, '1, 1'($urandom_range(0, 1)),
				1'b1, 1'b1, '1);
			3: begin
				// out-of-range and tiny widths, plus a write to the unused index
				w = $urandom_range(0, 1) ? 7'($urandom_range(0, 3)) :
					7'($urandom_range(64, 127));
				cfg_write(REG_UNUSED, {$urandom(), $urandom()});
				program_crc(w, {$urandom(), $urandom()}, {$urandom(), $urandom()},
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), {$urandom(), $urandom()});
			end
			default: program_crc(7'($urandom_range(1, 64)), {$urandom(), $urandom()},
				{$urandom(), $urandom()}, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				{$urandom(), $urandom()});
		endcase
	endtask

	// whole messages, mostly short, until about target bytes went out
	task automatic send_messages(input int target);
		int sent;
		int len;
		int i;
		sent = 0;
		while (sent < target) begin
			len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 40);
			for (i = 0; i < len; i++)
				send_byte(8'($urandom_range(0, 255)), i == len - 1);
			sent += len;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_CRC_WIDTH;
		cfg_data = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// reset setting, single-byte messages at the data extremes
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		wait_idle();

		// width zero acts as one, wide registers masked, non-direct init
		program_crc(7'd0, '1, '1, 1'b1, 1'b0, 1'b0, 64'h0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b1);
		wait_idle();

		// width one, reflected both ways, xor applied after reflection
		program_crc(7'd1, 64'h1, 64'h0, 1'b0, 1'b1, 1'b1, 64'h1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b1);
		wait_idle();

		// width above the maximum clamps to 64
		cfg_write(REG_UNUSED, '1);
		program_crc(7'd127, 64'h42F0_E1EB_A9EA_3693, '1, 1'b1, 1'b1, 1'b0, '1);
		send_byte(8'h31, 1'b0);
		send_byte(8'h32, 1'b0);
		send_byte(8'h33, 1'b1);
		wait_idle();

		// crc of zero sets the zero flag; garbage above the width is masked off
		program_crc(7'd8, 64'hDEAD_BEEF_0000_0007, 64'h0000_AB00, 1'b0, 1'b0, 1'b0,
			64'h1234_5600);
		send_byte(8'h00, 1'b1);
		wait_idle();

		// setting changed in the middle of a message
		program_crc(7'd16, 64'h1021, 64'hFFFF, 1'b0, 1'b0, 1'b0, 64'h0);
		send_byte(8'h31, 1'b0);
		send_byte(8'h32, 1'b0);
		wait_idle();
		cfg_write(REG_REFLECT_IN, 64'h1);
		cfg_write(REG_CRC_WIDTH, 64'd12);
		cfg_valid <= 1'b0;
		send_byte(8'h33, 1'b0);
		send_byte(8'h34, 1'b1);
		wait_idle();

		// random settings under each idling pattern
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 62; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 62; end
				default: begin src_idle_pct = 20; snk_stall_pct = 20; end
			endcase
			for (int s = 0; s < 2; s++) begin
				random_setting();
				// long output hold-off while bytes keep coming, fills the block
				if (p == 0 && s == 0) hold_req = HOLD_OFF_CYCLES;
				send_messages(105);
				wait_idle();
			end
		end

		$display("covered %0d bytes in %0d messages over %0d crc settings, %0d crcs checked",
			sb.n_bytes, n_msgs, n_settings, sb.n_checked);
		$display("widths 1 to 64 with clamping, both bit orders, non-direct init, "
			, "output hold-off");
		if (sb.n_fail == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
